// File: rtl/spq_pkg.sv
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // most records one remove may pop
  localparam logic [4:0] MAX_RUN = 5'd16;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    OUT_INSERTED = 2'd0,
    OUT_FULL     = 2'd1,
    OUT_POPPED   = 2'd2,
    OUT_EMPTY    = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_e;

  typedef struct packed {
    logic [63:0] name_first;
    logic [63:0] name_second;
    logic [6:0]  age;
    logic [1:0]  prio;
  } record_t;

  localparam int unsigned REC_W = $bits(record_t);

  typedef struct packed {
    logic     do_insert;  // write the input record to the tail of its class
    logic     rd_issue;   // read the head record of the lowest nonempty class
    logic     pop;        // retire the head record read last
    logic     out_load;   // load the output register
    logic     out_from_ram;
    outcome_e out_outcome;
    logic     out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic one_left;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/spq_ram.sv
module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/spq_ctrl.sv
module spq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [4:0]            remove_count_i,
  input  spq_pkg::dp_status_t   status_i,
  output spq_pkg::ctrl_cmd_t    cmd_o
);

  spq_pkg::state_e state_q, state_d;
  logic [4:0]      rem_q, rem_d;
  logic [4:0]      want;
  logic            accept;
  logic            is_insert;
  logic            last_pop;

  assign accept    = in_valid_i && (state_q == spq_pkg::S_IDLE) && status_i.out_free;
  assign in_stall_o = !((state_q == spq_pkg::S_IDLE) && status_i.out_free);
  assign is_insert = (req_type_i == spq_pkg::REQ_INSERT);

  // zero counts as one, anything above the run limit saturates
  always_comb begin
    if (remove_count_i == 5'd0) begin
      want = 5'd1;
    end else if (remove_count_i > spq_pkg::MAX_RUN) begin
      want = spq_pkg::MAX_RUN;
    end else begin
      want = remove_count_i;
    end
  end

  assign last_pop = (rem_q == 5'd1) || status_i.one_left;

  // next state
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    case (state_q)
      spq_pkg::S_IDLE: begin
        if (accept && !is_insert && !status_i.empty) begin
          state_d = spq_pkg::S_READ;
          rem_d   = want;
        end
      end
      spq_pkg::S_READ: begin
        state_d = spq_pkg::S_LOAD;
      end
      spq_pkg::S_LOAD: begin
        if (status_i.out_free) begin
          rem_d   = rem_q - 5'd1;
          state_d = last_pop ? spq_pkg::S_IDLE : spq_pkg::S_READ;
        end
      end
      default: begin
        state_d = spq_pkg::S_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o              = '0;
    cmd_o.out_outcome  = spq_pkg::OUT_INSERTED;
    case (state_q)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          if (is_insert) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_last = 1'b1;
            if (status_i.full) begin
              cmd_o.out_outcome = spq_pkg::OUT_FULL;
            end else begin
              cmd_o.do_insert   = 1'b1;
              cmd_o.out_outcome = spq_pkg::OUT_INSERTED;
            end
          end else if (status_i.empty) begin
            cmd_o.out_load    = 1'b1;
            cmd_o.out_last    = 1'b1;
            cmd_o.out_outcome = spq_pkg::OUT_EMPTY;
          end
        end
      end
      spq_pkg::S_READ: begin
        cmd_o.rd_issue = 1'b1;
      end
      spq_pkg::S_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.pop          = 1'b1;
          cmd_o.out_from_ram = 1'b1;
          cmd_o.out_outcome  = spq_pkg::OUT_POPPED;
          cmd_o.out_last     = last_pop;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::S_IDLE;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// File: rtl/spq_datapath.sv
module spq_datapath #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::ctrl_cmd_t  cmd_i,
  output spq_pkg::dp_status_t status_o,
  input  logic [63:0]         name_first_half_i,
  input  logic [63:0]         name_second_half_i,
  input  logic [6:0]          age_i,
  input  logic [1:0]          priority_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          outcome_o,
  output logic [63:0]         out_name_first_o,
  output logic [63:0]         out_name_second_o,
  output logic [6:0]          out_age_o,
  output logic [1:0]          out_priority_o,
  output logic                last_of_run_o
);

  localparam int unsigned PW        = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RAM_DEPTH = 4 * (2 ** PW);

  // one FIFO region per priority value; head of the queue is the oldest
  // record of the lowest nonempty class
  logic [PW-1:0] head_q [4];
  logic [PW-1:0] tail_q [4];
  logic [CW-1:0] cnt_q  [4];
  logic [CW-1:0] total_q;
  logic [1:0]    pop_prio_q;
  logic [1:0]    sel_prio;

  logic            out_valid_q;
  spq_pkg::outcome_e outcome_q;
  spq_pkg::record_t  out_rec_q;
  logic            last_q;

  spq_pkg::record_t wr_rec;
  spq_pkg::record_t rd_rec;
  logic [spq_pkg::REC_W-1:0] rd_data;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  always_comb begin
    sel_prio = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        sel_prio = 2'(i);
      end
    end
  end

  assign wr_rec.name_first  = name_first_half_i;
  assign wr_rec.name_second = name_second_half_i;
  assign wr_rec.age         = age_i;
  assign wr_rec.prio        = priority_req_i;

  spq_ram #(
    .WIDTH(spq_pkg::REC_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.do_insert),
    .wr_addr_i({priority_req_i, tail_q[priority_req_i]}),
    .wr_data_i(wr_rec),
    .rd_en_i  (cmd_i.rd_issue),
    .rd_addr_i({sel_prio, head_q[sel_prio]}),
    .rd_data_o(rd_data)
  );

  assign rd_rec = spq_pkg::record_t'(rd_data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      total_q    <= '0;
      pop_prio_q <= '0;
    end else begin
      if (cmd_i.do_insert) begin
        tail_q[priority_req_i] <= ptr_inc(tail_q[priority_req_i]);
        cnt_q[priority_req_i]  <= cnt_q[priority_req_i] + CW'(1);
        total_q                <= total_q + CW'(1);
      end
      if (cmd_i.rd_issue) begin
        pop_prio_q <= sel_prio;
      end
      if (cmd_i.pop) begin
        head_q[pop_prio_q] <= ptr_inc(head_q[pop_prio_q]);
        cnt_q[pop_prio_q]  <= cnt_q[pop_prio_q] - CW'(1);
        total_q            <= total_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      outcome_q <= cmd_i.out_outcome;
      last_q    <= cmd_i.out_last;
      out_rec_q <= cmd_i.out_from_ram ? rd_rec : '0;
    end
  end

  assign status_o.full     = (total_q == CW'(QUEUE_DEPTH));
  assign status_o.empty    = (total_q == '0);
  assign status_o.one_left = (total_q == CW'(1));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign outcome_o         = outcome_q;
  assign out_name_first_o  = out_rec_q.name_first;
  assign out_name_second_o = out_rec_q.name_second;
  assign out_age_o         = out_rec_q.age;
  assign out_priority_o    = out_rec_q.prio;
  assign last_of_run_o     = last_q;

endmodule

// File: rtl/stable_priority_queue.sv
// Stable priority queue of up to QUEUE_DEPTH records (16-byte name, age, 2-bit
// priority value). Smaller priority values leave first; equal values leave in
// arrival order. An insert returns one word (inserted, or full). A remove of
// n records is first accepted; then, for each popped record, the head record
// is read through the registered read port of the record RAM and then loaded
// into the output register, and the load waits while the output side stalls.
// A remove on an empty queue returns a single empty word. Each input word is
// accepted only once all words of the previous one have been loaded. The RAM
// holds four regions of 2^ceil(log2(QUEUE_DEPTH)) records, one per priority
// value, and needs no clearing pass after reset.
module stable_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [63:0] name_first_half_i,
  input  logic [63:0] name_second_half_i,
  input  logic [6:0]  age_i,
  input  logic [1:0]  priority_req_i,
  input  logic [4:0]  remove_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  outcome_o,
  output logic [63:0] out_name_first_o,
  output logic [63:0] out_name_second_o,
  output logic [6:0]  out_age_o,
  output logic [1:0]  out_priority_o,
  output logic        last_of_run_o
);

  spq_pkg::ctrl_cmd_t  cmd;
  spq_pkg::dp_status_t status;

  spq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .remove_count_i(remove_count_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .name_first_half_i (name_first_half_i),
    .name_second_half_i(name_second_half_i),
    .age_i             (age_i),
    .priority_req_i    (priority_req_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .outcome_o         (outcome_o),
    .out_name_first_o  (out_name_first_o),
    .out_name_second_o (out_name_second_o),
    .out_age_o         (out_age_o),
    .out_priority_o    (out_priority_o),
    .last_of_run_o     (last_of_run_o)
  );

`ifndef SYNTHESIS
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !status.empty)
    else $error("pop with empty queue");

  a_no_insert_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_insert |-> !status.full)
    else $error("insert with full queue");

  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.pop && !cmd.out_last) |=> !status.empty)
    else $error("unmarked pop left the queue empty");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten");
`endif

endmodule
